@@ hdl/mke_pkg.sv @@
package mke_pkg;

   localparam int UNIT_W  = 8;
   localparam int PAD_W   = 10;
   localparam int RUN_W   = 11;
   localparam int CHAR_W  = 8;
   localparam int OP_W    = 2;
   localparam int CODE_W  = 6;
   localparam int CLEN_W  = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_CHAR  = 2'd1,
      OP_END   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNIT_BITS = 4'd0,
      CSR_PAD_BITS  = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_PAD    = 2'd0,
      KIND_SPACE  = 2'd1,
      KIND_SYMBOL = 2'd2
   } kind_type;

   // elements left-aligned, first element in the top bit, 1 = dash
   typedef struct packed {
      logic [CLEN_W-1:0] len;
      logic [CODE_W-1:0] pat;
   } code_type;

   typedef struct packed {
      kind_type kind;
      logic     lead_gap;
      code_type code;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'd32;

   function automatic code_type mk_code(input logic [CLEN_W-1:0] n,
                                        input logic [CODE_W-1:0] p);
      code_type c;
      c.len = n;
      c.pat = p;
      return c;
   endfunction

   function automatic code_type code_lookup(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] c;
      code_type r;
      c = ch;
      if (c >= "a" && c <= "z") begin
         c = c - CASE_DIFF;
      end
      case (c)
         "A": r = mk_code(3'd2, 6'b01_0000);
         "B": r = mk_code(3'd4, 6'b1000_00);
         "C": r = mk_code(3'd4, 6'b1010_00);
         "D": r = mk_code(3'd3, 6'b100_000);
         "E": r = mk_code(3'd1, 6'b0_00000);
         "F": r = mk_code(3'd4, 6'b0010_00);
         "G": r = mk_code(3'd3, 6'b110_000);
         "H": r = mk_code(3'd4, 6'b0000_00);
         "I": r = mk_code(3'd2, 6'b00_0000);
         "J": r = mk_code(3'd4, 6'b0111_00);
         "K": r = mk_code(3'd3, 6'b101_000);
         "L": r = mk_code(3'd4, 6'b0100_00);
         "M": r = mk_code(3'd2, 6'b11_0000);
         "N": r = mk_code(3'd2, 6'b10_0000);
         "O": r = mk_code(3'd3, 6'b111_000);
         "P": r = mk_code(3'd4, 6'b0110_00);
         "Q": r = mk_code(3'd4, 6'b1101_00);
         "R": r = mk_code(3'd3, 6'b010_000);
         "S": r = mk_code(3'd3, 6'b000_000);
         "T": r = mk_code(3'd1, 6'b1_00000);
         "U": r = mk_code(3'd3, 6'b001_000);
         "V": r = mk_code(3'd4, 6'b0001_00);
         "W": r = mk_code(3'd3, 6'b011_000);
         "X": r = mk_code(3'd4, 6'b1001_00);
         "Y": r = mk_code(3'd4, 6'b1011_00);
         "Z": r = mk_code(3'd4, 6'b1100_00);
         "0": r = mk_code(3'd5, 6'b11111_0);
         "1": r = mk_code(3'd5, 6'b01111_0);
         "2": r = mk_code(3'd5, 6'b00111_0);
         "3": r = mk_code(3'd5, 6'b00011_0);
         "4": r = mk_code(3'd5, 6'b00001_0);
         "5": r = mk_code(3'd5, 6'b00000_0);
         "6": r = mk_code(3'd5, 6'b10000_0);
         "7": r = mk_code(3'd5, 6'b11000_0);
         "8": r = mk_code(3'd5, 6'b11100_0);
         "9": r = mk_code(3'd5, 6'b11110_0);
         ".": r = mk_code(3'd6, 6'b010101);
         ",": r = mk_code(3'd6, 6'b110011);
         "?": r = mk_code(3'd6, 6'b001100);
         default: r = mk_code(3'd1, 6'b1_00000);
      endcase
      return r;
   endfunction

endpackage

@@ hdl/mke_front.sv @@
module mke_front
   import mke_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [OP_W-1:0]        req_op,
   input  logic [CHAR_W-1:0]      req_char_code,
   input  logic [PAD_W-1:0]       pad_bits,
   input  queue_status_type       q_status,
   output logic                   q_push,
   output desc_type               q_desc
);

   logic prev_symbol_ff;
   logic prev_symbol_in;
   logic accept;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   always_comb begin
      prev_symbol_in = prev_symbol_ff;
      q_push         = 1'b0;
      q_desc.kind     = KIND_PAD;
      q_desc.lead_gap = prev_symbol_ff;
      q_desc.code     = code_lookup(req_char_code);
      if (accept) begin
         unique case (op_type'(req_op)) inside
            OP_START, OP_END: begin
               prev_symbol_in = 1'b0;
               q_push         = (pad_bits != '0);
               q_desc.kind    = KIND_PAD;
            end
            OP_CHAR: begin
               q_push = 1'b1;
               if (req_char_code == CHAR_SPACE) begin
                  q_desc.kind    = KIND_SPACE;
                  prev_symbol_in = 1'b0;
               end else begin
                  q_desc.kind    = KIND_SYMBOL;
                  prev_symbol_in = 1'b1;
               end
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_symbol_ff <= 1'b0;
      end else begin
         prev_symbol_ff <= prev_symbol_in;
      end
   end

endmodule

@@ hdl/mke_queue.sv @@
module mke_queue
   import mke_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  desc_type         wr_data,
   input  logic             rd_en,
   output desc_type         rd_data,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign rd_data      = entry_ff[rd_ptr_ff];
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hdl/mke_back.sv @@
module mke_back
   import mke_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  desc_type           q_desc,
   input  queue_status_type   q_status,
   output logic               q_pop,
   input  logic [RUN_W-1:0]   unit,
   input  logic [PAD_W-1:0]   pad_bits,
   output logic               empty,
   input  logic               pop,
   output logic               rsp_level,
   output logic [RUN_W-1:0]   rsp_run_bits,
   output logic               rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_SPACE = 6'b000100,
      ST_LEAD  = 6'b001000,
      ST_MARK  = 6'b010000,
      ST_GAP   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CODE_W-1:0]  pat_ff, pat_in;
   logic [CLEN_W-1:0]  rem_ff, rem_in;
   logic               out_valid_ff, out_valid_in;
   logic               level_ff, level_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic               last_ff, last_in;

   logic [RUN_W-1:0]   unit3;
   logic [RUN_W-1:0]   unit7;
   logic               advance;
   logic               emit;
   logic               finishing;
   state_type          next_run_state;

   assign unit3 = unit + (unit << 1);
   assign unit7 = (unit << 3) - unit;

   assign advance = !out_valid_ff || pop;
   assign emit    = (state_ff != ST_IDLE) && advance;

   assign empty        = !out_valid_ff;
   assign rsp_level    = level_ff;
   assign rsp_run_bits = run_ff;
   assign rsp_last     = last_ff;

   always_comb begin
      level_in       = 1'b0;
      run_in         = unit;
      last_in        = 1'b0;
      next_run_state = state_ff;
      pat_in         = pat_ff;
      rem_in         = rem_ff;
      unique case (state_ff)
         ST_IDLE: begin
            next_run_state = ST_IDLE;
         end
         ST_PAD: begin
            run_in  = RUN_W'(pad_bits);
            last_in = 1'b1;
         end
         ST_SPACE: begin
            run_in  = unit7;
            last_in = 1'b1;
         end
         ST_LEAD: begin
            run_in         = unit3;
            next_run_state = ST_MARK;
         end
         ST_MARK: begin
            level_in       = 1'b1;
            run_in         = pat_ff[CODE_W-1] ? unit3 : unit;
            last_in        = (rem_ff == CLEN_W'(1));
            next_run_state = ST_GAP;
            pat_in         = pat_ff << 1;
            rem_in         = rem_ff - 1'b1;
         end
         ST_GAP: begin
            run_in         = unit;
            next_run_state = ST_MARK;
         end
         default: begin
            next_run_state = ST_IDLE;
         end
      endcase
   end

   assign finishing = (state_ff == ST_IDLE) || (emit && last_in);
   assign q_pop     = finishing && !q_status.empty;

   always_comb begin
      state_in = state_ff;
      if (q_pop) begin
         unique case (q_desc.kind)
            KIND_PAD:    state_in = ST_PAD;
            KIND_SPACE:  state_in = ST_SPACE;
            KIND_SYMBOL: state_in = q_desc.lead_gap ? ST_LEAD : ST_MARK;
            default:     state_in = ST_IDLE;
         endcase
      end else if (finishing) begin
         state_in = ST_IDLE;
      end else if (emit) begin
         state_in = next_run_state;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         pat_ff <= q_desc.code.pat;
         rem_ff <= q_desc.code.len;
      end else if (emit) begin
         pat_ff <= pat_in;
         rem_ff <= rem_in;
      end
      if (emit) begin
         level_ff <= level_in;
         run_ff   <= run_in;
         last_ff  <= last_in;
      end
   end

endmodule

@@ hdl/morse_keying_encoder.sv @@
// Morse on-off keying encoder. Push one request per message item (start, character, end);
// pop the keyed signal as runs of equal bits, each a level and a length in bits. A front
// stage classifies each request and looks up its Morse pattern, then a
// descriptor queue of QUEUE_DEPTH entries feeds a run sequencer that issues one run per
// cycle into the output register, unless a full output register waits for pop. An item
// yields one run for padding or a space, up to twelve for a character (letter gap, up to
// six marks and the gaps between them); an item with no run is dropped in the front stage.
// The sequencer loads the next descriptor in the cycle of the last run, so back-to-back
// items run without a bubble; an idle sequencer first loads its state register.
// Write unit_bits (index 0) and pad_bits (index 1) only while the block is idle.
module morse_keying_encoder
   import mke_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [OP_W-1:0]       req_op,
   input  logic [CHAR_W-1:0]     req_char_code,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_level,
   output logic [RUN_W-1:0]      rsp_run_bits,
   output logic                  rsp_last,
   input  logic                  valid,
   output logic                  ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [UNIT_W-1:0]  unit_bits_ff;
   logic [PAD_W-1:0]   pad_bits_ff;
   logic [RUN_W-1:0]   unit;
   logic               q_push;
   logic               q_pop;
   desc_type           q_wr_desc;
   desc_type           q_rd_desc;
   queue_status_type   q_status;

   assign ready = 1'b1;
   assign unit  = (unit_bits_ff == '0) ? RUN_W'(1) : RUN_W'(unit_bits_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_bits_ff <= UNIT_W'(1);
         pad_bits_ff  <= '0;
      end else if (valid && ready) begin
         unique case (csr_index)
            CSR_UNIT_BITS: unit_bits_ff <= csr_data[UNIT_W-1:0];
            CSR_PAD_BITS:  pad_bits_ff  <= csr_data[PAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mke_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .pad_bits      (pad_bits_ff),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_desc        (q_wr_desc)
   );

   mke_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_desc),
      .rd_en   (q_pop),
      .rd_data (q_rd_desc),
      .status  (q_status)
   );

   mke_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_desc       (q_rd_desc),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .unit         (unit),
      .pad_bits     (pad_bits_ff),
      .empty        (empty),
      .pop          (pop),
      .rsp_level    (rsp_level),
      .rsp_run_bits (rsp_run_bits),
      .rsp_last     (rsp_last)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("descriptor taken from an empty queue");

   a_mark_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_level) |-> (rsp_run_bits == unit || rsp_run_bits == unit * 3))
      else $error("mark run is neither a dot nor a dash");

   a_gap_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_level && !rsp_last) |->
         (rsp_run_bits == unit || rsp_run_bits == unit * 3))
      else $error("inner gap run has a bad length");

endmodule
